[rtl/multi_channel_message_queues_assert.svh]
// Assertion macros for the mailbox engine.
`ifndef MULTI_CHANNEL_MESSAGE_QUEUES_ASSERT_SVH
`define MULTI_CHANNEL_MESSAGE_QUEUES_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define MCMQ_ASSERT_IMP(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the next cycle.
`define MCMQ_ASSERT_NEXT(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed");
`endif

[rtl/mcmq_pkg.sv]
// Package with types, codes and constants of the mailbox engine.
`timescale 1ns / 1ps
package mcmq_pkg;
  localparam int CHANNELS_DEF = 8;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int BODY_WIDTH_DEF = 64;

  typedef enum logic [3:0] {
    OP_OPEN = 4'd0, OP_CLOSE = 4'd1, OP_SEND = 4'd2, OP_SEND_TO = 4'd3,
    OP_BROADCAST = 4'd4, OP_RECEIVE = 4'd5, OP_PEEK = 4'd6, OP_PENDING = 4'd7,
    OP_TICK = 4'd8
  } op_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_INACTIVE = 3'd1, ST_FULL = 3'd2, ST_EMPTY = 3'd3,
    ST_NOFREE = 3'd4, ST_NOSUB = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_EXEC, S_READ, S_DONE
  } state_t;

  typedef struct packed {
    logic [3:0]  op;
    logic [2:0]  channel;
    logic [31:0] subscriber;
    logic [63:0] payload;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  channel_out;
    logic [63:0] payload_out;
    logic [31:0] stamp_out;
    logic        pending;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic scan_step;
    logic exec;
    logic read;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic needs_scan;
    logic scan_last;
    logic needs_read;
  } stat_t;
endpackage

[rtl/mcmq_ctrl.sv]
// Controller state machine of the mailbox engine.
`timescale 1ns / 1ps
module mcmq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  mcmq_pkg::stat_t stat,
  output mcmq_pkg::cmd_t  cmd
);
  mcmq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mcmq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      mcmq_pkg::S_IDLE: begin
        if (in_valid) state_next = mcmq_pkg::S_SCAN;
      end
      mcmq_pkg::S_SCAN: begin
        if (!stat.needs_scan || stat.scan_last) state_next = mcmq_pkg::S_EXEC;
      end
      mcmq_pkg::S_EXEC: begin
        state_next = stat.needs_read ? mcmq_pkg::S_READ : mcmq_pkg::S_DONE;
      end
      mcmq_pkg::S_READ: state_next = mcmq_pkg::S_DONE;
      mcmq_pkg::S_DONE: begin
        if (out_ready) state_next = mcmq_pkg::S_IDLE;
      end
      default: state_next = mcmq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    out_valid = 1'b0;
    cmd = '0;
    case (state)
      mcmq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      mcmq_pkg::S_SCAN: cmd.scan_step = stat.needs_scan;
      mcmq_pkg::S_EXEC: cmd.exec = 1'b1;
      mcmq_pkg::S_READ: cmd.read = 1'b1;
      mcmq_pkg::S_DONE: out_valid = 1'b1;
      default: ;
    endcase
  end
endmodule

[rtl/mcmq_datapath.sv]
// Channel table, queue memories and channel scan of the mailbox engine.
`timescale 1ns / 1ps
module mcmq_datapath #(
  parameter int CHANNELS = mcmq_pkg::CHANNELS_DEF,
  parameter int QUEUE_DEPTH = mcmq_pkg::QUEUE_DEPTH_DEF,
  parameter int BODY_WIDTH = mcmq_pkg::BODY_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  mcmq_pkg::in_item_t  in_item,
  input  mcmq_pkg::cmd_t      cmd,
  output mcmq_pkg::stat_t     stat,
  output mcmq_pkg::out_item_t out_item
);
  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = CW + PW;
  localparam int OW = $clog2(CHANNELS + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [FW-1:0] FILL_FULL = FW'(QUEUE_DEPTH);

  logic [CHANNELS-1:0] active;
  logic [31:0]         sub_id [CHANNELS];
  logic [PW-1:0]       rd_ptr [CHANNELS];
  logic [PW-1:0]       wr_ptr [CHANNELS];
  logic [FW-1:0]       fill   [CHANNELS];
  logic [31:0]         tick_count;
  logic [OW-1:0]       open_count;

  logic [BODY_WIDTH-1:0] body_mem  [2**AW];
  logic [31:0]           stamp_mem [2**AW];

  mcmq_pkg::in_item_t item;
  logic [CW-1:0] scan_idx;
  logic          found;
  logic [CW-1:0] found_idx;

  // Target channel chosen at execution or, for broadcast, at each scan step.
  logic          tgt_ok;
  logic [CW-1:0] tgt;
  logic          ch_valid;
  logic [CW-1:0] ch;
  logic          is_scan_op;

  logic [BODY_WIDTH-1:0] rd_body;
  logic [31:0]           rd_stamp;
  logic                  push_en;
  logic [AW-1:0]         push_addr;

  assign ch_valid = (int'(item.channel) < CHANNELS);
  assign ch = CW'(item.channel);
  assign is_scan_op = (item.op == mcmq_pkg::OP_OPEN) || (item.op == mcmq_pkg::OP_SEND_TO)
                      || (item.op == mcmq_pkg::OP_BROADCAST);
  assign stat.needs_scan = is_scan_op;
  assign stat.scan_last = (scan_idx == CW'(CHANNELS - 1)) ||
                          (item.op != mcmq_pkg::OP_BROADCAST && found);
  assign stat.needs_read = (item.op == mcmq_pkg::OP_RECEIVE || item.op == mcmq_pkg::OP_PEEK)
                           && ch_valid && active[ch] && fill[ch] != '0;

  // Broadcast pushes one channel per scan step; open and send_to search.
  logic scan_hit;
  always_comb begin
    scan_hit = 1'b0;
    case (item.op)
      mcmq_pkg::OP_OPEN:      scan_hit = !active[scan_idx];
      mcmq_pkg::OP_SEND_TO:   scan_hit = active[scan_idx] &&
                                         sub_id[scan_idx] == item.subscriber;
      mcmq_pkg::OP_BROADCAST: scan_hit = active[scan_idx] && fill[scan_idx] != FILL_FULL;
      default:                scan_hit = 1'b0;
    endcase
  end

  always_comb begin
    push_en = 1'b0;
    tgt = ch;
    tgt_ok = ch_valid && active[ch];
    if (item.op == mcmq_pkg::OP_SEND_TO) begin
      tgt = found_idx;
      tgt_ok = found;
    end
    if (cmd.scan_step && item.op == mcmq_pkg::OP_BROADCAST) begin
      push_en = scan_hit;
      tgt = scan_idx;
    end else if (cmd.exec && (item.op == mcmq_pkg::OP_SEND ||
                              item.op == mcmq_pkg::OP_SEND_TO)) begin
      push_en = tgt_ok && fill[tgt] != FILL_FULL;
    end
    push_addr = {tgt, wr_ptr[tgt]};
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      body_mem[push_addr] <= item.payload[BODY_WIDTH-1:0];
      stamp_mem[push_addr] <= tick_count;
    end
    if (cmd.read) begin
      rd_body <= body_mem[{ch, rd_ptr[ch]}];
      rd_stamp <= stamp_mem[{ch, rd_ptr[ch]}];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item <= in_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      tick_count <= '0;
      open_count <= '0;
      scan_idx <= '0;
      found <= 1'b0;
      found_idx <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        sub_id[i] <= '0;
        rd_ptr[i] <= '0;
        wr_ptr[i] <= '0;
        fill[i] <= '0;
      end
    end else begin
      if (cmd.load) begin
        scan_idx <= '0;
        found <= 1'b0;
        found_idx <= '0;
      end
      if (cmd.scan_step) begin
        if (scan_idx != CW'(CHANNELS - 1)) scan_idx <= scan_idx + 1'b1;
        if (scan_hit && !found) begin
          found <= 1'b1;
          found_idx <= scan_idx;
        end
      end
      if (push_en) begin
        wr_ptr[tgt] <= (wr_ptr[tgt] == PTR_LAST) ? '0 : wr_ptr[tgt] + 1'b1;
        fill[tgt] <= fill[tgt] + 1'b1;
      end
      if (cmd.exec) begin
        case (item.op)
          mcmq_pkg::OP_OPEN: begin
            if (found) begin
              active[found_idx] <= 1'b1;
              sub_id[found_idx] <= item.subscriber;
              rd_ptr[found_idx] <= '0;
              wr_ptr[found_idx] <= '0;
              fill[found_idx] <= '0;
              open_count <= open_count + 1'b1;
            end
          end
          mcmq_pkg::OP_CLOSE: begin
            if (tgt_ok) begin
              active[ch] <= 1'b0;
              sub_id[ch] <= '0;
              rd_ptr[ch] <= '0;
              wr_ptr[ch] <= '0;
              fill[ch] <= '0;
              open_count <= open_count - 1'b1;
            end
          end
          mcmq_pkg::OP_TICK: tick_count <= tick_count + 1'b1;
          default: ;
        endcase
      end
      if (cmd.read && item.op == mcmq_pkg::OP_RECEIVE) begin
        rd_ptr[ch] <= (rd_ptr[ch] == PTR_LAST) ? '0 : rd_ptr[ch] + 1'b1;
        fill[ch] <= fill[ch] - 1'b1;
      end
    end
  end

  // The result is built at execution and held until the transaction completes.
  logic [2:0]  res_status;
  logic [2:0]  res_chan;
  logic        res_pend;
  logic        res_read;
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status <= mcmq_pkg::ST_OK;
      res_chan <= '0;
      res_pend <= 1'b0;
      res_read <= 1'b0;
      case (item.op)
        mcmq_pkg::OP_OPEN: begin
          if (found) res_chan <= 3'(found_idx);
          else res_status <= mcmq_pkg::ST_NOFREE;
        end
        mcmq_pkg::OP_CLOSE: if (!tgt_ok) res_status <= mcmq_pkg::ST_INACTIVE;
        mcmq_pkg::OP_SEND: begin
          if (!tgt_ok) res_status <= mcmq_pkg::ST_INACTIVE;
          else if (fill[tgt] == FILL_FULL) res_status <= mcmq_pkg::ST_FULL;
        end
        mcmq_pkg::OP_SEND_TO: begin
          if (!found) res_status <= mcmq_pkg::ST_NOSUB;
          else begin
            res_chan <= 3'(found_idx);
            if (fill[tgt] == FILL_FULL) res_status <= mcmq_pkg::ST_FULL;
          end
        end
        mcmq_pkg::OP_RECEIVE, mcmq_pkg::OP_PEEK: begin
          if (!tgt_ok) res_status <= mcmq_pkg::ST_INACTIVE;
          else if (fill[ch] == '0) res_status <= mcmq_pkg::ST_EMPTY;
          else res_read <= 1'b1;
        end
        mcmq_pkg::OP_PENDING: res_pend <= tgt_ok && fill[ch] != '0;
        default: ;
      endcase
    end
  end

  always_comb begin
    out_item = '0;
    out_item.status = res_status;
    out_item.channel_out = res_chan;
    out_item.pending = res_pend;
    if (res_read) begin
      out_item.payload_out = 64'(rd_body);
      out_item.stamp_out = rd_stamp;
    end
  end
endmodule

[rtl/multi_channel_message_queues.sv]
// Top level of the multi-channel mailbox engine.
// One transaction at a time: after acceptance every operation passes through the
// scan, execute and done states; receive and peek add a read state (registered
// queue memory read); open, send_to and broadcast step through the sequential
// channel scan, one channel per step, over up to CHANNELS channels. Results hold
// until taken, and the next transaction is accepted in the cycle after that.
`timescale 1ns / 1ps
`include "multi_channel_message_queues_assert.svh"
module multi_channel_message_queues #(
  parameter int CHANNELS = mcmq_pkg::CHANNELS_DEF,
  parameter int QUEUE_DEPTH = mcmq_pkg::QUEUE_DEPTH_DEF,
  parameter int BODY_WIDTH = mcmq_pkg::BODY_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mcmq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mcmq_pkg::out_item_t out_data
);
  mcmq_pkg::cmd_t  cmd;
  mcmq_pkg::stat_t stat;

  mcmq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
  );

  mcmq_datapath #(
    .CHANNELS(CHANNELS), .QUEUE_DEPTH(QUEUE_DEPTH), .BODY_WIDTH(BODY_WIDTH)
  ) u_dp (
    .clk(clk), .rst(rst), .in_item(in_data), .cmd(cmd), .stat(stat),
    .out_item(out_data)
  );

  `MCMQ_ASSERT_IMP(a_no_overlap, in_ready, !out_valid)
  `MCMQ_ASSERT_NEXT(a_done_after_take, out_valid && out_ready, in_ready)
  `MCMQ_ASSERT_IMP(a_one_cmd, 1'b1, $onehot0({cmd.load, cmd.exec, cmd.read}))
endmodule
